### sv/ssfe_pkg.sv
// ----------------------------------------------------------------------------
// ssfe_pkg: shared definitions for the surd square factor extractor
// Field widths, rule codes, sequencer states and divider status.
// ----------------------------------------------------------------------------
package ssfe_pkg;

  localparam int RADICAND_BITS = 32;
  localparam int MAX_RESULTS   = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int VALUE_W = 32;
  localparam int COEFF_W = 16;
  localparam int RAD_W   = 32;
  localparam int RULE_W  = 3;

  typedef enum logic [RULE_W-1:0] {
    RULE_NONE        = 3'd0,
    RULE_FOUR        = 3'd1,
    RULE_NINE        = 3'd2,
    RULE_TWENTY_FIVE = 3'd3,
    RULE_TRIAL       = 3'd4
  } rule_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRY4,
    ST_FIT,
    ST_DIV,
    ST_FOUND,
    ST_FLUSH,
    ST_NONE
  } back_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/ssfe_if.sv
// ----------------------------------------------------------------------------
// ssfe_if: item channels of the surd square factor extractor
// Input channel carries one radicand, output channel one step result.
// ----------------------------------------------------------------------------
interface ssfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssfe_pkg::VALUE_W-1:0]  value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface ssfe_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssfe_pkg::COEFF_W-1:0]  coeff;
  logic [ssfe_pkg::RAD_W-1:0]    new_radicand;
  logic [ssfe_pkg::RAD_W-1:0]    prev_radicand;
  logic [ssfe_pkg::RAD_W-1:0]    square_removed;
  logic [ssfe_pkg::RULE_W-1:0]   rule_used;
  logic                          last;

  modport source (output valid, output coeff, output new_radicand, output prev_radicand,
                  output square_removed, output rule_used, output last, input ready);
  modport sink   (input valid, input coeff, input new_radicand, input prev_radicand,
                  input square_removed, input rule_used, input last, output ready);
endinterface

### sv/ssfe_front.sv
// ----------------------------------------------------------------------------
// ssfe_front: input stage
// Accepts items, trims the radicand to its width and flags zero.
// ----------------------------------------------------------------------------
module ssfe_front #(
  parameter int RADICAND_BITS = ssfe_pkg::RADICAND_BITS
) (
  ssfe_in_if.sink                  in_i,
  input  logic                     full_i,
  output logic                     push_o,
  output logic [RADICAND_BITS:0]   data_o
);

  logic [63:0]              value_ext;
  logic [RADICAND_BITS-1:0] rad;

  assign value_ext = 64'(in_i.value_in);
  assign rad       = value_ext[RADICAND_BITS-1:0];

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  // msb flags a zero radicand
  assign data_o     = {(rad == '0), rad};

endmodule

### sv/ssfe_queue.sv
// ----------------------------------------------------------------------------
// ssfe_queue: short FIFO between front and back
// Register based, one push (not full) and one pop (not empty) per cycle.
// ----------------------------------------------------------------------------
module ssfe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ssfe_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

### sv/ssfe_div.sv
// ----------------------------------------------------------------------------
// ssfe_div: iterative restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssfe_div #(
  parameter int RADICAND_BITS = ssfe_pkg::RADICAND_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [RADICAND_BITS-1:0]  dividend_i,
  input  logic [RADICAND_BITS-1:0]  divisor_i,
  output ssfe_pkg::div_stat_t       stat_o,
  output logic [RADICAND_BITS-1:0]  quotient_o,
  output logic [RADICAND_BITS-1:0]  remainder_o
);

  localparam int RB = RADICAND_BITS;
  localparam int CW = $clog2(RB);

  logic [RB-1:0] rem_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [RB:0]   trial;
  logic          fits;
  logic [RB:0]   diff;

  assign trial = {rem_q, quo_q[RB-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RB - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[RB-1:0] : trial[RB-1:0];
      quo_q <= {quo_q[RB-2:0], fits};
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

### sv/ssfe_back.sv
// ----------------------------------------------------------------------------
// ssfe_back: step sequencer
// Tries the rules per step, holds one step back to mark the last one,
// and drives the output register.
// ----------------------------------------------------------------------------
module ssfe_back #(
  parameter int RADICAND_BITS = ssfe_pkg::RADICAND_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  logic [RADICAND_BITS:0]    q_data_i,
  output logic                      q_pop_o,
  output logic                      div_start_o,
  output logic [RADICAND_BITS-1:0]  div_dividend_o,
  output logic [RADICAND_BITS-1:0]  div_divisor_o,
  input  ssfe_pkg::div_stat_t       div_stat_i,
  input  logic [RADICAND_BITS-1:0]  div_quotient_i,
  input  logic [RADICAND_BITS-1:0]  div_remainder_i,
  ssfe_out_if.source                out_o
);

  localparam int RB  = RADICAND_BITS;
  localparam int SQW = RB + 2;
  localparam int RTW = RB / 2 + 2;
  localparam int CW  = $clog2(ssfe_pkg::MAX_RESULTS + 1);
  localparam int CF  = ssfe_pkg::COEFF_W;

  ssfe_pkg::back_state_e state_q, state_d;

  logic [RB-1:0]  r_q, r_d;
  logic [CF-1:0]  c_q, c_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  logic [SQW-1:0]   cand_sq_q, cand_sq_d;
  logic [RTW-1:0]   cand_root_q, cand_root_d;
  ssfe_pkg::rule_e  cand_rule_q, cand_rule_d;
  logic             cand_hi_q, cand_hi_d;

  logic [CF-1:0]    st_coeff_q, st_coeff_d;
  logic [RB-1:0]    st_next_q, st_next_d;
  logic [SQW-1:0]   st_sq_q, st_sq_d;
  ssfe_pkg::rule_e  st_rule_q, st_rule_d;

  logic             pend_v_q, pend_v_d;
  logic [CF-1:0]    pend_coeff_q, pend_coeff_d;
  logic [RB-1:0]    pend_next_q, pend_next_d;
  logic [RB-1:0]    pend_prev_q, pend_prev_d;
  logic [SQW-1:0]   pend_sq_q, pend_sq_d;
  ssfe_pkg::rule_e  pend_rule_q, pend_rule_d;

  logic                          out_v_q, out_v_d;
  logic [CF-1:0]                 out_coeff_q, out_coeff_d;
  logic [ssfe_pkg::RAD_W-1:0]    out_new_q, out_new_d;
  logic [ssfe_pkg::RAD_W-1:0]    out_prev_q, out_prev_d;
  logic [ssfe_pkg::RAD_W-1:0]    out_sq_q, out_sq_d;
  ssfe_pkg::rule_e               out_rule_q, out_rule_d;
  logic                          out_last_q, out_last_d;

  logic        out_free;
  logic [63:0] r64, pend_next64, pend_prev64, pend_sq64;
  logic [31:0] root_ext;

  assign out_free    = !out_v_q || out_o.ready;
  assign r64         = 64'(r_q);
  assign pend_next64 = 64'(pend_next_q);
  assign pend_prev64 = 64'(pend_prev_q);
  assign pend_sq64   = 64'(pend_sq_q);
  assign root_ext    = 32'(cand_root_q);

  assign div_dividend_o = r_q;
  assign div_divisor_o  = cand_sq_q[RB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ssfe_pkg::ST_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q          <= r_d;
    c_q          <= c_d;
    cand_sq_q    <= cand_sq_d;
    cand_root_q  <= cand_root_d;
    cand_rule_q  <= cand_rule_d;
    cand_hi_q    <= cand_hi_d;
    st_coeff_q   <= st_coeff_d;
    st_next_q    <= st_next_d;
    st_sq_q      <= st_sq_d;
    st_rule_q    <= st_rule_d;
    pend_coeff_q <= pend_coeff_d;
    pend_next_q  <= pend_next_d;
    pend_prev_q  <= pend_prev_d;
    pend_sq_q    <= pend_sq_d;
    pend_rule_q  <= pend_rule_d;
    out_coeff_q  <= out_coeff_d;
    out_new_q    <= out_new_d;
    out_prev_q   <= out_prev_d;
    out_sq_q     <= out_sq_d;
    out_rule_q   <= out_rule_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    r_d          = r_q;
    c_d          = c_q;
    cnt_d        = cnt_q;
    cand_sq_d    = cand_sq_q;
    cand_root_d  = cand_root_q;
    cand_rule_d  = cand_rule_q;
    cand_hi_d    = cand_hi_q;
    st_coeff_d   = st_coeff_q;
    st_next_d    = st_next_q;
    st_sq_d      = st_sq_q;
    st_rule_d    = st_rule_q;
    pend_v_d     = pend_v_q;
    pend_coeff_d = pend_coeff_q;
    pend_next_d  = pend_next_q;
    pend_prev_d  = pend_prev_q;
    pend_sq_d    = pend_sq_q;
    pend_rule_d  = pend_rule_q;
    out_v_d      = out_v_q;
    out_coeff_d  = out_coeff_q;
    out_new_d    = out_new_q;
    out_prev_d   = out_prev_q;
    out_sq_d     = out_sq_q;
    out_rule_d   = out_rule_q;
    out_last_d   = out_last_q;
    q_pop_o      = 1'b0;
    div_start_o  = 1'b0;

    if (out_v_q && out_o.ready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      ssfe_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          r_d      = q_data_i[RB-1:0];
          c_d      = CF'(1);
          cnt_d    = '0;
          pend_v_d = 1'b0;
          state_d  = q_data_i[RB] ? ssfe_pkg::ST_NONE : ssfe_pkg::ST_TRY4;
        end
      end
      ssfe_pkg::ST_TRY4: begin
        if (r_q[1:0] == 2'b00) begin
          st_coeff_d = {c_q[CF-2:0], 1'b0};
          st_next_d  = r_q >> 2;
          st_sq_d    = SQW'(4);
          st_rule_d  = ssfe_pkg::RULE_FOUR;
          state_d    = ssfe_pkg::ST_FOUND;
        end else begin
          cand_sq_d   = SQW'(9);
          cand_root_d = RTW'(3);
          cand_rule_d = ssfe_pkg::RULE_NINE;
          cand_hi_d   = 1'b0;
          state_d     = ssfe_pkg::ST_FIT;
        end
      end
      ssfe_pkg::ST_FIT: begin
        // candidates never shrink, so the first one above r ends the search
        if (cand_sq_q <= SQW'(r_q)) begin
          div_start_o = 1'b1;
          state_d     = ssfe_pkg::ST_DIV;
        end else begin
          state_d = pend_v_q ? ssfe_pkg::ST_FLUSH : ssfe_pkg::ST_NONE;
        end
      end
      ssfe_pkg::ST_DIV: begin
        if (div_stat_i.done) begin
          if (div_remainder_i == '0) begin
            st_coeff_d = CF'(c_q * root_ext[CF-1:0]);
            st_next_d  = div_quotient_i;
            st_sq_d    = cand_sq_q;
            st_rule_d  = cand_rule_q;
            state_d    = ssfe_pkg::ST_FOUND;
          end else begin
            case (cand_rule_q)
              ssfe_pkg::RULE_NINE: begin
                cand_sq_d   = SQW'(25);
                cand_root_d = RTW'(5);
                cand_rule_d = ssfe_pkg::RULE_TWENTY_FIVE;
              end
              ssfe_pkg::RULE_TWENTY_FIVE: begin
                cand_sq_d   = SQW'(25);
                cand_root_d = RTW'(5);
                cand_rule_d = ssfe_pkg::RULE_TRIAL;
                cand_hi_d   = 1'b0;
              end
              default: begin
                // (a+2)^2 = a^2+4a+4 ; (a+4)^2 = a^2+8a+16
                if (cand_hi_q) begin
                  cand_sq_d   = cand_sq_q + (SQW'(cand_root_q) << 3) + SQW'(16);
                  cand_root_d = cand_root_q + RTW'(4);
                  cand_hi_d   = 1'b0;
                end else begin
                  cand_sq_d   = cand_sq_q + (SQW'(cand_root_q) << 2) + SQW'(4);
                  cand_root_d = cand_root_q + RTW'(2);
                  cand_hi_d   = 1'b1;
                end
              end
            endcase
            state_d = ssfe_pkg::ST_FIT;
          end
        end
      end
      ssfe_pkg::ST_FOUND: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d     = 1'b1;
            out_coeff_d = pend_coeff_q;
            out_new_d   = pend_next64[ssfe_pkg::RAD_W-1:0];
            out_prev_d  = pend_prev64[ssfe_pkg::RAD_W-1:0];
            out_sq_d    = pend_sq64[ssfe_pkg::RAD_W-1:0];
            out_rule_d  = pend_rule_q;
            out_last_d  = 1'b0;
          end
          pend_v_d     = 1'b1;
          pend_coeff_d = st_coeff_q;
          pend_next_d  = st_next_q;
          pend_prev_d  = r_q;
          pend_sq_d    = st_sq_q;
          pend_rule_d  = st_rule_q;
          c_d          = st_coeff_q;
          r_d          = st_next_q;
          cnt_d        = cnt_q + 1'b1;
          if (CW'(cnt_q + 1'b1) == CW'(ssfe_pkg::MAX_RESULTS)) begin
            state_d = ssfe_pkg::ST_FLUSH;
          end else begin
            state_d = ssfe_pkg::ST_TRY4;
          end
        end
      end
      ssfe_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_coeff_d = pend_coeff_q;
          out_new_d   = pend_next64[ssfe_pkg::RAD_W-1:0];
          out_prev_d  = pend_prev64[ssfe_pkg::RAD_W-1:0];
          out_sq_d    = pend_sq64[ssfe_pkg::RAD_W-1:0];
          out_rule_d  = pend_rule_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ssfe_pkg::ST_IDLE;
        end
      end
      ssfe_pkg::ST_NONE: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_coeff_d = CF'(1);
          out_new_d   = r64[ssfe_pkg::RAD_W-1:0];
          out_prev_d  = r64[ssfe_pkg::RAD_W-1:0];
          out_sq_d    = '0;
          out_rule_d  = ssfe_pkg::RULE_NONE;
          out_last_d  = 1'b1;
          state_d     = ssfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_o.valid          = out_v_q;
  assign out_o.coeff          = out_coeff_q;
  assign out_o.new_radicand   = out_new_q;
  assign out_o.prev_radicand  = out_prev_q;
  assign out_o.square_removed = out_sq_q;
  assign out_o.rule_used      = out_rule_q;
  assign out_o.last           = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssfe_pkg::ST_DIV) |-> (div_stat_i.busy || div_stat_i.done))
    else $error("waiting on divider that is not running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_rule_q == ssfe_pkg::RULE_NONE) |-> out_last_q)
    else $error("rule none item without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (cnt_q != '0))
    else $error("held step without a step count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ssfe_pkg::MAX_RESULTS))
    else $error("step count above cap");

endmodule

### sv/surd_square_factor_extractor.sv
// ----------------------------------------------------------------------------
// surd_square_factor_extractor: square factor extraction for a radicand
// Front accepts radicands into a short queue; the back sequencer divides
// out one square per step and emits one item per step.
// ----------------------------------------------------------------------------
// Steps: the rule four test comes first after an item is popped; every other candidate
//   square (9, 25, then 25, 49, 121, 169, ...) is tried in the bit-serial divider;
//   one item per step, the item of the last step carries last, and a single rule none
//   item with last if no square divides out.
// Flow: one radicand at a time in the back; divider runs and output back-pressure set the pace.
// Reset: asynchronous active low, clears queue, sequencer and output valid.
module surd_square_factor_extractor #(
  parameter int RADICAND_BITS = ssfe_pkg::RADICAND_BITS,
  parameter int QUEUE_DEPTH   = ssfe_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssfe_in_if.sink     in_i,
  ssfe_out_if.source  out_o
);

  logic                      q_full, q_push, q_valid, q_pop;
  logic [RADICAND_BITS:0]    q_wdata, q_rdata;
  logic                      div_start;
  logic [RADICAND_BITS-1:0]  div_dividend, div_divisor, div_quotient, div_remainder;
  ssfe_pkg::div_stat_t       div_stat;

  ssfe_front #(
    .RADICAND_BITS (RADICAND_BITS)
  ) u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (q_push),
    .data_o (q_wdata)
  );

  ssfe_queue #(
    .WIDTH (RADICAND_BITS + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  ssfe_div #(
    .RADICAND_BITS (RADICAND_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  ssfe_back #(
    .RADICAND_BITS (RADICAND_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .div_start_o     (div_start),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_stat_i      (div_stat),
    .div_quotient_i  (div_quotient),
    .div_remainder_i (div_remainder),
    .out_o           (out_o)
  );

endmodule
